### rtl/sbhe_pkg.sv
// Shared constants and types of the strip bitmap hit extractor.
package sbhe_pkg;

   // Event layout
   localparam int EVT_HDR      = 14;
   localparam int MOD_HDR      = 3;
   localparam int STR_HDR      = 3;
   localparam int STREAM_BYTES = 160;
   localparam int MAX_MODULES  = 16;
   localparam int MOD_SIZE     = MOD_HDR + 2 * (STR_HDR + STREAM_BYTES);
   localparam int S0_START     = MOD_HDR + STR_HDR;
   localparam int S1_START     = S0_START + STREAM_BYTES + STR_HDR;

   // Field widths
   localparam int DATA_W = 8;
   localparam int LEN_W  = 13;
   localparam int X_W    = 11;
   localparam int Y_W    = 6;
   localparam int CNT_W  = 5;
   localparam int BIT_W  = 3;
   localparam int IDX_W  = X_W - BIT_W;

   // Position counters
   localparam int MOD_IDX_W = $clog2(MAX_MODULES + 1);
   localparam int OFF_W     = $clog2(MOD_SIZE);
   localparam int POS_MAX   = 2 ** LEN_W - 1;

   // Module count by reciprocal multiply: exact for any 13-bit length
   localparam int RECIP_SHIFT = 23;
   localparam int RECIP_MULT  = (2 ** RECIP_SHIFT + MOD_SIZE - 1) / MOD_SIZE;
   localparam int PROD_W      = RECIP_SHIFT + LEN_W;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified byte: hit bits still to expand, plus marker info
   typedef struct packed {
      logic [DATA_W-1:0] mask;
      logic [IDX_W-1:0]  idx;
      logic [Y_W-1:0]    row;
      logic              is_last;
      logic [CNT_W-1:0]  mod_count;
   } entry_type;

endpackage

### rtl/sbhe_channels.sv
// Valid/ready channel interfaces for the request bytes and the hit results.
interface sbhe_req_if;
   logic                       valid;
   logic                       ready;
   logic [sbhe_pkg::DATA_W-1:0] data_byte;
   logic [sbhe_pkg::LEN_W-1:0]  event_bytes;
   logic                       last_byte;

   modport source (output valid, data_byte, event_bytes, last_byte, input ready);
   modport sink   (input valid, data_byte, event_bytes, last_byte, output ready);
endinterface

interface sbhe_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      is_event_end;
   logic [sbhe_pkg::X_W-1:0]   hit_x;
   logic [sbhe_pkg::Y_W-1:0]   hit_y;
   logic [sbhe_pkg::CNT_W-1:0] module_count;
   logic                      last_of_run;

   modport source (output valid, is_event_end, hit_x, hit_y, module_count, last_of_run,
                   input ready);
   modport sink   (input valid, is_event_end, hit_x, hit_y, module_count, last_of_run,
                   output ready);
endinterface

### rtl/sbhe_front.sv
// Front end: accepts bytes, tracks event position, classifies each byte.
module sbhe_front (
   input  logic                clock,
   input  logic                reset,
   sbhe_req_if.sink            req_chan,
   input  logic                q_full,
   output logic                q_push,
   output sbhe_pkg::entry_type q_entry
);
   import sbhe_pkg::*;

   logic [LEN_W-1:0]     pos_ff, pos_in;
   logic [MOD_IDX_W-1:0] mod_ff, mod_in;
   logic [OFF_W-1:0]     off_ff, off_in;

   logic                 accept;
   logic                 in_hdr;
   logic                 in_s0, in_s1;
   logic                 hit_en;
   logic [LEN_W-1:0]     len_body;
   logic [PROD_W-1:0]    prod;
   logic [LEN_W-1:0]     quot;
   logic [MOD_IDX_W-1:0] count;
   logic [OFF_W-1:0]     off_rel;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   // complete modules = (len - hdr) / MOD_SIZE, capped
   assign len_body = req_chan.event_bytes - LEN_W'(EVT_HDR);
   assign prod     = PROD_W'(len_body) * PROD_W'(RECIP_MULT);
   assign quot     = prod[RECIP_SHIFT +: LEN_W];

   always_comb begin
      if (req_chan.event_bytes < LEN_W'(EVT_HDR)) begin
         count = '0;
      end else if (quot > LEN_W'(MAX_MODULES)) begin
         count = MOD_IDX_W'(MAX_MODULES);
      end else begin
         count = quot[MOD_IDX_W-1:0];
      end
   end

   assign in_hdr  = pos_ff < LEN_W'(EVT_HDR);
   assign in_s0   = (off_ff >= OFF_W'(S0_START)) && (off_ff < OFF_W'(S0_START + STREAM_BYTES));
   assign in_s1   = off_ff >= OFF_W'(S1_START);
   assign off_rel = in_s1 ? off_ff - OFF_W'(S1_START) : off_ff - OFF_W'(S0_START);
   assign hit_en  = !in_hdr && (in_s0 || in_s1) && (mod_ff < count);

   always_comb begin
      q_entry.mask      = hit_en ? req_chan.data_byte : '0;
      q_entry.idx       = IDX_W'(off_rel);
      q_entry.row       = Y_W'({mod_ff, in_s1}) + Y_W'(1);
      q_entry.is_last   = req_chan.last_byte;
      q_entry.mod_count = CNT_W'(count);
   end

   // bytes with no hits and no marker produce nothing
   assign q_push = accept && ((q_entry.mask != '0) || req_chan.last_byte);

   always_comb begin
      pos_in = pos_ff;
      mod_in = mod_ff;
      off_in = off_ff;
      if (accept) begin
         if (req_chan.last_byte) begin
            pos_in = '0;
            mod_in = '0;
            off_in = '0;
         end else begin
            if (pos_ff != LEN_W'(POS_MAX)) begin
               pos_in = pos_ff + LEN_W'(1);
            end
            if (!in_hdr && (mod_ff < MOD_IDX_W'(MAX_MODULES))) begin
               if (off_ff == OFF_W'(MOD_SIZE - 1)) begin
                  off_in = '0;
                  mod_in = mod_ff + MOD_IDX_W'(1);
               end else begin
                  off_in = off_ff + OFF_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         mod_ff <= '0;
         off_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         mod_ff <= mod_in;
         off_ff <= off_in;
      end
   end

   a_off_range: assert property (@(posedge clock) disable iff (reset)
      off_ff <= OFF_W'(MOD_SIZE - 1))
      else $error("module offset out of range");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.last_byte |=> pos_ff == '0 && mod_ff == '0 && off_ff == '0)
      else $error("position not cleared after last byte");

endmodule

### rtl/sbhe_queue.sv
// Short FIFO of classified bytes between front and back end.
module sbhe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sbhe_pkg::entry_type push_entry,
   output logic                full,
   output logic                head_valid,
   output sbhe_pkg::entry_type head_entry,
   input  logic                pop
);
   import sbhe_pkg::*;

   entry_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

endmodule

### rtl/sbhe_back.sv
// Back end: expands hit bits one per cycle while the output is free, then the end marker.
module sbhe_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  sbhe_pkg::entry_type head_entry,
   output logic                pop,
   sbhe_rsp_if.source          rsp_chan
);
   import sbhe_pkg::*;

   logic                 work_vld_ff, work_vld_in;
   entry_type            work_ff, work_in;

   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 end_ff, end_in;
   logic [X_W-1:0]       x_ff, x_in;
   logic [Y_W-1:0]       y_ff, y_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 lor_ff, lor_in;

   logic                 out_free;
   logic                 emit;
   logic                 is_marker;
   logic                 fin;
   logic [BIT_W-1:0]     low_bit;
   logic [DATA_W-1:0]    rem_mask;

   assign out_free  = !rsp_vld_ff || rsp_chan.ready;
   assign emit      = work_vld_ff && out_free;
   assign is_marker = work_ff.mask == '0;
   assign rem_mask  = work_ff.mask & (work_ff.mask - DATA_W'(1));
   assign fin       = emit && (is_marker || (rem_mask == '0 && !work_ff.is_last));
   assign pop       = head_valid && (!work_vld_ff || fin);

   // lowest set bit goes first
   always_comb begin
      low_bit = '0;
      for (int i = DATA_W - 1; i >= 0; i--) begin
         if (work_ff.mask[i]) begin
            low_bit = BIT_W'(i);
         end
      end
   end

   always_comb begin
      work_vld_in = work_vld_ff;
      work_in     = work_ff;
      if (pop) begin
         work_vld_in = 1'b1;
         work_in     = head_entry;
      end else if (fin) begin
         work_vld_in = 1'b0;
      end else if (emit) begin
         work_in.mask = rem_mask;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      end_in     = end_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      cnt_in     = cnt_ff;
      lor_in     = lor_ff;
      if (emit) begin
         rsp_vld_in = 1'b1;
         end_in     = is_marker;
         x_in       = is_marker ? '0 : {work_ff.idx, low_bit};
         y_in       = is_marker ? '0 : work_ff.row;
         cnt_in     = is_marker ? work_ff.mod_count : '0;
         lor_in     = fin;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         work_vld_ff <= work_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      end_ff  <= end_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      cnt_ff  <= cnt_in;
      lor_ff  <= lor_in;
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.is_event_end = end_ff;
   assign rsp_chan.hit_x        = x_ff;
   assign rsp_chan.hit_y        = y_ff;
   assign rsp_chan.module_count = cnt_ff;
   assign rsp_chan.last_of_run  = lor_ff;

   a_work_nonempty: assert property (@(posedge clock) disable iff (reset)
      work_vld_ff |-> work_ff.mask != '0 || work_ff.is_last)
      else $error("empty entry reached back end");

   a_marker_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && end_ff |-> lor_ff && x_ff == '0 && y_ff == '0)
      else $error("end marker malformed");

endmodule

### rtl/strip_bitmap_hit_extractor.sv
// Top level of the strip bitmap hit extractor: front, queue and back end.
//
// Usage:
//   req_chan carries the raw event bytes in order, one per transfer, with the
//   event's total length on every byte and last_byte on the final one.
//   rsp_chan returns a transfer per set bit of full modules (LSB first), with
//   hit_x = byte offset in stream * 8 + bit and hit_y = module * 2 + 1 + stream,
//   and after the final byte an end marker carrying the complete module count.
//   last_of_run flags the final transfer caused by one input byte.
// A byte reaches rsp_chan through the queue, work register and output register.
// Throughput: one input byte per cycle while each byte yields at most one
//   result and rsp_chan is ready; the back end emits one result per cycle
//   unless stalled, so a byte with n hits (plus marker) holds the output longer.
// The 4-entry queue between front and back absorbs such bursts; when it
//   fills, req_chan.ready drops. A stalled receiver holds the output register
//   and backs up through the queue; no result is lost or repeated.
// Reset (synchronous) clears the position counters, the queue and the
//   output register; the block takes bytes in the cycle after reset.
module strip_bitmap_hit_extractor (
   input  logic        clock,
   input  logic        reset,
   sbhe_req_if.sink    req_chan,
   sbhe_rsp_if.source  rsp_chan
);
   import sbhe_pkg::*;

   logic      q_push;
   logic      q_full;
   logic      q_head_valid;
   logic      q_pop;
   entry_type q_push_entry;
   entry_type q_head_entry;

   // classify bytes and advance the event position
   sbhe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_push_entry)
   );

   // decouples byte intake from hit expansion
   sbhe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop)
   );

   // one result per cycle into the output register while it is free
   sbhe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

### tb/tb_strip_bitmap_hit_extractor.sv
// Self-checking testbench for the strip bitmap hit extractor.
`timescale 1ns / 1ps

module tb_strip_bitmap_hit_extractor;
   import sbhe_pkg::*;

   // Event layout, written out from the format description rather than
   // taken from the package, so a wrong package constant shows up as a miss.
   localparam int unsigned HDR_EVENT     = 14;
   localparam int unsigned HDR_MODULE    = 3;
   localparam int unsigned HDR_STREAM    = 3;
   localparam int unsigned BITMAP_BYTES  = 160;
   localparam int unsigned MODULES_MAX   = 16;
   localparam int unsigned MODULE_BYTES  = HDR_MODULE + 2 * (HDR_STREAM + BITMAP_BYTES);
   localparam int unsigned FIRST_BITMAP  = HDR_MODULE + HDR_STREAM;
   localparam int unsigned SECOND_BITMAP = FIRST_BITMAP + BITMAP_BYTES + HDR_STREAM;
   localparam int unsigned LEN_MAX       = 2 ** LEN_W - 1;

   // Run control; RANDOM_BYTES counts every byte send_event sends with idling
   // on, the pressure event included
   localparam int unsigned RANDOM_BYTES    = 270;
   localparam int unsigned PRESSURE_CYCLES = 150;
   // Drain margin, sized for a full 4-entry queue of 9-result bytes.
   localparam int unsigned DRAIN_CYCLES    = 48;
   // Well above the slowest correct run (every byte behind the longest gap,
   // nine results per byte each behind the longest stall).
   localparam int unsigned CYCLE_LIMIT     = 1_000_000;

   // One result transfer as seen on rsp_chan
   typedef struct packed {
      logic             is_event_end;
      logic [X_W-1:0]   hit_x;
      logic [Y_W-1:0]   hit_y;
      logic [CNT_W-1:0] module_count;
      logic             last_of_run;
   } strip_result_type;

   // Directed stimulus row; pinned rows carry an end marker typed in by hand
   typedef struct {
      logic [DATA_W-1:0] data;
      logic [LEN_W-1:0]  len;
      logic              last;
      int unsigned       reps;
      bit                pinned;
      logic [CNT_W-1:0]  count;
   } stim_row_type;

   typedef struct {
      bit               pinned;
      logic [CNT_W-1:0] count;
   } marker_pin_type;

   logic clock;
   logic reset;

   sbhe_req_if req_chan ();
   sbhe_rsp_if rsp_chan ();

   strip_bitmap_hit_extractor i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Directed part. Single-byte events after reset or after a marker sit in
   // the event header, so their only result is the marker and its module
   // count can be read straight off the length.
   stim_row_type directed_rows [9] = '{
      '{8'hFF, 13'd0,    1'b1, 1,  1'b1, 5'd0},   // zero length, all bits set
      '{8'h00, 13'd8191, 1'b1, 1,  1'b1, 5'd16},  // longest length, count capped
      '{8'h5A, 13'd342,  1'b1, 1,  1'b1, 5'd0},   // one byte short of a module
      '{8'hA5, 13'd343,  1'b1, 1,  1'b1, 5'd1},   // exactly one module
      '{8'hC3, 13'd8191, 1'b0, 20, 1'b0, 5'd0},   // event/module/stream headers
      '{8'h01, 13'd8191, 1'b0, 1,  1'b0, 5'd0},   // first strip of module 0
      '{8'h80, 13'd8191, 1'b0, 1,  1'b0, 5'd0},   // top bit of next byte
      '{8'h00, 13'd8191, 1'b0, 1,  1'b0, 5'd0},   // bitmap byte, no hits
      '{8'hFF, 13'd8191, 1'b1, 1,  1'b0, 5'd0}    // eight hits plus marker
   };

   // Predictor state, mirrors the block's position counters
   logic [LEN_W-1:0] ev_pos    = '0;
   logic [4:0]       ev_module = '0;
   logic [8:0]       ev_offset = '0;

   strip_result_type pending_hits [$];   // expected results, oldest first
   strip_result_type byte_hits    [$];   // results of the byte in hand
   marker_pin_type   marker_pins  [$];   // per offered byte, in order

   bit          idling_on;
   bit          pressure_req;
   int unsigned ready_hold;
   int unsigned cycle_count;
   int unsigned mismatches;
   int unsigned bytes_accepted;
   int unsigned results_checked;
   int unsigned hits_seen;
   int unsigned markers_seen;
   int unsigned random_bytes;
   int unsigned events_sent;

   // Hit extraction for one accepted byte: fills byte_hits, steps the counters
   function automatic void extract_hits(input logic [DATA_W-1:0] data,
                                        input logic [LEN_W-1:0] len,
                                        input logic last);
      int unsigned      full_modules;
      int unsigned      stream_sel;
      int unsigned      idx;
      int unsigned      b;
      bit               in_bitmap;
      strip_result_type r;

      byte_hits.delete();
      full_modules = 0;
      if (len >= HDR_EVENT) begin
         full_modules = (len - HDR_EVENT) / MODULE_BYTES;
         if (full_modules > MODULES_MAX) full_modules = MODULES_MAX;
      end

      if (ev_pos >= HDR_EVENT) begin
         in_bitmap  = 1'b0;
         stream_sel = 0;
         idx        = 0;
         if (ev_offset >= FIRST_BITMAP && ev_offset < FIRST_BITMAP + BITMAP_BYTES) begin
            in_bitmap = 1'b1;
            idx       = ev_offset - FIRST_BITMAP;
         end else if (ev_offset >= SECOND_BITMAP &&
                      ev_offset < SECOND_BITMAP + BITMAP_BYTES) begin
            in_bitmap  = 1'b1;
            stream_sel = 1;
            idx        = ev_offset - SECOND_BITMAP;
         end
         // modules at or past the complete count are dropped
         if (in_bitmap && ev_module < full_modules) begin
            for (b = 0; b < 8; b++) begin
               if (data[b]) begin
                  r         = '0;
                  r.hit_x   = X_W'(idx * 8 + b);
                  r.hit_y   = Y_W'(ev_module * 2 + 1 + stream_sel);
                  byte_hits = {byte_hits, r};
               end
            end
         end
         // counters freeze once past the last module slot
         if (ev_module < MODULES_MAX) begin
            ev_offset++;
            if (ev_offset >= MODULE_BYTES) begin
               ev_offset = '0;
               ev_module++;
            end
         end
      end
      if (ev_pos != LEN_MAX) ev_pos++;

      if (last) begin
         r              = '0;
         r.is_event_end = 1'b1;
         r.module_count = CNT_W'(full_modules);
         byte_hits      = {byte_hits, r};
         ev_pos    = '0;
         ev_module = '0;
         ev_offset = '0;
      end
      if (byte_hits.size() != 0) byte_hits[byte_hits.size() - 1].last_of_run = 1'b1;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endfunction

   // Offer one byte, with an occasional gap in front, and wait for the transfer
   task automatic offer_byte(input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] len,
                             input logic last, input bit pinned,
                             input logic [CNT_W-1:0] count);
      marker_pin_type pin;
      if (idling_on && $urandom_range(0, 9) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      pin.pinned  = pinned;
      pin.count   = count;
      marker_pins = {marker_pins, pin};
      req_chan.valid       <= 1'b1;
      req_chan.data_byte   <= data;
      req_chan.event_bytes <= len;
      req_chan.last_byte   <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // One event of nbytes bytes; a noisy event changes its length on every byte.
   // density is the percentage of bytes that carry random bits.
   task automatic send_event(input int unsigned nbytes, input logic [LEN_W-1:0] len,
                             input bit noisy, input int unsigned density);
      int unsigned       k;
      logic [DATA_W-1:0] d;
      logic [LEN_W-1:0]  l;
      for (k = 0; k < nbytes; k++) begin
         l = noisy ? LEN_W'($urandom_range(0, LEN_MAX)) : len;
         d = '0;
         if ($urandom_range(0, 99) < density) begin
            d = DATA_W'($urandom_range(0, 255));
            if ($urandom_range(0, 15) == 0) d = '1;
         end
         offer_byte(d, l, k == nbytes - 1, 1'b0, '0);
         if (idling_on) random_bytes++;
      end
      events_sent++;
   endtask

   // Input side: every transfer runs through the predictor; pinned rows
   // replace its output with the hand-typed marker.
   always @(posedge clock) begin : byte_monitor
      marker_pin_type   pin;
      strip_result_type r;
      if (!reset && req_chan.valid && req_chan.ready) begin
         pin = marker_pins.pop_front();
         extract_hits(req_chan.data_byte, req_chan.event_bytes, req_chan.last_byte);
         if (pin.pinned) begin
            r              = '0;
            r.is_event_end = 1'b1;
            r.module_count = pin.count;
            r.last_of_run  = 1'b1;
            pending_hits   = {pending_hits, r};
         end else begin
            pending_hits = {pending_hits, byte_hits};
         end
         bytes_accepted++;
      end
   end

   // Output side: compare each transfer against the oldest expectation
   always @(posedge clock) begin : hit_checker
      strip_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_hits.size() == 0) begin
            $error("unexpected result: end %0b x %0d y %0d count %0d",
                   rsp_chan.is_event_end, rsp_chan.hit_x, rsp_chan.hit_y,
                   rsp_chan.module_count);
            mismatches++;
         end else begin
            want = pending_hits.pop_front();
            check_field("is_event_end", want.is_event_end, rsp_chan.is_event_end);
            check_field("hit_x", want.hit_x, rsp_chan.hit_x);
            check_field("hit_y", want.hit_y, rsp_chan.hit_y);
            check_field("module_count", want.module_count, rsp_chan.module_count);
            check_field("last_of_run", want.last_of_run, rsp_chan.last_of_run);
            if (want.is_event_end) markers_seen++;
            else hits_seen++;
            results_checked++;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request so the
   // internal queue fills and req_chan.ready has to drop.
   always @(posedge clock) begin
      if (pressure_req) begin
         pressure_req = 1'b0;
         ready_hold   = PRESSURE_CYCLES;
      end else if (ready_hold == 0 && idling_on && $urandom_range(0, 9) == 0) begin
         ready_hold = $urandom_range(1, 19);
      end
      if (ready_hold != 0) begin
         rsp_chan.ready <= 1'b0;
         ready_hold--;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) cycle_count++;

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_hits.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int unsigned      rep;
      int unsigned      nbytes;
      int unsigned      pick;
      logic [LEN_W-1:0] len;
      int unsigned      edge_lens [7];

      edge_lens = '{13, 14, 342, 343, 671, 672, 8191};

      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.data_byte   = '0;
      req_chan.event_bytes = '0;
      req_chan.last_byte   = 1'b0;
      rsp_chan.ready       = 1'b0;
      idling_on            = 1'b1;
      pressure_req         = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         for (rep = 0; rep < directed_rows[i].reps; rep++) begin
            offer_byte(directed_rows[i].data, directed_rows[i].len,
                       directed_rows[i].last && rep == directed_rows[i].reps - 1,
                       directed_rows[i].pinned, directed_rows[i].count);
         end
      end

      // Dense event while the receiver holds off: hits pile up behind the
      // output register and the block must throttle its input. It runs on
      // into the second stream of module 0.
      pressure_req = 1'b1;
      send_event(190, 13'd8191, 1'b0, 90);

      // Mostly consistent events with random content; lengths favor counts
      // of one or more modules, with the count boundaries mixed in.
      while (random_bytes < RANDOM_BYTES) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) len = LEN_W'($urandom_range(HDR_EVENT + MODULE_BYTES, LEN_MAX));
         else if (pick == 6) len = LEN_W'(edge_lens[$urandom_range(0, 6)]);
         else if (pick == 7) len = LEN_W'($urandom_range(0, LEN_MAX));
         else len = LEN_W'(HDR_EVENT + MODULE_BYTES * $urandom_range(1, MODULES_MAX) +
                           $urandom_range(0, MODULE_BYTES - 1));
         nbytes = $urandom_range(1, 30);
         if (nbytes > RANDOM_BYTES - random_bytes) nbytes = RANDOM_BYTES - random_bytes;
         send_event(nbytes, len, $urandom_range(0, 4) == 0, 60);
      end

      // Last stretch runs flat out: an event with no complete module, then
      // back-to-back bitmap bytes of module 0.
      idling_on = 1'b0;
      send_event(25, 13'd342, 1'b0, 60);
      send_event(40, 13'd8191, 1'b0, 60);
      send_event(1, 13'd8191, 1'b0, 100);

      req_chan.valid     <= 1'b0;
      req_chan.last_byte <= 1'b0;
      @(posedge clock);
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d bytes in %0d events, %0d hits and %0d end markers checked",
               bytes_accepted, events_sent, hits_seen, markers_seen);
      $display("%0d mismatches over %0d cycles", mismatches, cycle_count);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
